// ===== design/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// chr_pkg
// Shared constants, types and helper functions for the canyon height recast
// pipeline.
// ----------------------------------------------------------------------------
package chr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int LOG_FRAC   = 24;
    localparam int EXP_FRAC   = 30;
    localparam int GAMMA_FRAC = 12;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUT_MODE   = 2'd0,
        CFG_SCALAR_CUT = 2'd1,
        CFG_CURVE_EXP  = 2'd2,
        CFG_MASK_EN    = 2'd3
    } t_cfg_idx;

    // Cut modes; any other code selects the scalar cut without noise.
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_NOISY = 2'd2;

    localparam logic [1:0]  CUT_MODE_RST   = MODE_PIXEL;
    localparam logic [31:0] SCALAR_CUT_RST = 32'(64'd1 << (FRAC_BITS - 1));
    localparam logic [15:0] CURVE_EXP_RST  = 16'd4096;

    localparam logic [16:0] MASK_FULL = 17'd65536;
    localparam logic [40:0] MAG_MAX   = 41'h100_0000_0000;
    localparam logic [30:0] EXP_ONE   = 31'h4000_0000;

    typedef enum logic [1:0] {
        KIND_PASS  = 2'd0,
        KIND_DOM   = 2'd1,
        KIND_CURVE = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [31:0] h;
        logic [31:0]        ac;
        logic               cut_neg;
        t_kind              kind;
        logic [15:0]        gamma;
        logic               men;
        logic [16:0]        mw;
    } t_ctx;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Factor 2^(2^-k) in Q.30, built by repeated truncating square roots.
    function automatic logic [30:0] exp_tab(input int k);
        logic [63:0] t;
        t = 64'd2 << EXP_FRAC;
        for (int j = 1; j <= LOG_FRAC; j++) begin
            if (j <= k) begin
                t = isqrt64(t << EXP_FRAC);
            end
        end
        return t[30:0];
    endfunction

    function automatic logic [5:0] msb_idx(input logic [32:0] x);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < 33; i++) begin
            if (x[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/canyon_height_recast.sv =====
// ----------------------------------------------------------------------------
// canyon_height_recast
// Throughput: one word per cycle, set by the fully pipelined log2 and exp2
// chains (one squaring of each mantissa or one constant multiply per stage).
// Reset: synchronous, active low; clears the valid bits and the configuration
// registers to their reset values. The receiver cannot stall, so busy is only held in reset.
// ----------------------------------------------------------------------------
module canyon_height_recast
    import chr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [31:0]          i_height,
    input  logic [31:0]          i_pixel_cut,
    input  logic [31:0]          i_noise,
    input  logic [16:0]          i_mask_weight,
    output logic                 o_strobe,
    output logic [31:0]          o_new_height,
    output logic                 o_domain_flag
);

    localparam int ST_LOG0 = 2;
    localparam int ST_L    = ST_LOG0 + LOG_FRAC + 1;
    localparam int ST_PG   = ST_L + 1;
    localparam int ST_EXP0 = ST_PG + 1;
    localparam int ST_PROD = ST_EXP0 + LOG_FRAC + 1;
    localparam int ST_MAG  = ST_PROD + 1;
    localparam int ST_F    = ST_MAG + 1;
    localparam int ST_BP   = ST_F + 1;
    localparam int NST     = ST_BP + 1;
    localparam int LAT     = NST + 2;

    logic [1:0]         r_cut_mode;
    logic signed [31:0] r_scalar_cut;
    logic [15:0]        r_curve_exp;
    logic               r_mask_en;

    logic               r_a_vld;
    logic signed [31:0] r_a_h;
    logic signed [31:0] r_a_cut;
    logic signed [32:0] r_a_d;
    logic [16:0]        r_a_mw;
    logic [15:0]        r_a_gamma;
    logic               r_a_men;

    logic               r_vld [NST];
    t_ctx               r_ctx [NST];

    logic [32:0]        r_ah;
    logic [32:0]        r_ad;
    logic [5:0]         r_eh;
    logic [5:0]         r_ed;
    logic [32:0]        r_ah_c;
    logic [32:0]        r_ad_c;

    logic [31:0]        r_lm_h [LOG_FRAC+1];
    logic [31:0]        r_lm_d [LOG_FRAC+1];
    logic [23:0]        r_lf_h [LOG_FRAC+1];
    logic [23:0]        r_lf_d [LOG_FRAC+1];
    logic [5:0]         r_le_h [LOG_FRAC+1];
    logic [5:0]         r_le_d [LOG_FRAC+1];

    logic signed [30:0] r_l;
    logic signed [47:0] r_pg;

    logic [30:0]        r_acc [LOG_FRAC+1];
    logic [23:0]        r_fp  [LOG_FRAC+1];
    logic signed [11:0] r_s   [LOG_FRAC+1];

    logic [62:0]        r_prod;
    logic signed [11:0] r_s_p;
    logic [40:0]        r_mag;
    logic [31:0]        r_fsat;
    logic               r_flag_f;
    logic signed [50:0] r_bp;
    logic               r_flag_b;
    logic [31:0]        r_fsat_b;

    logic               n_accept;
    logic signed [31:0] n_cut;
    logic signed [32:0] n_d;
    logic [16:0]        n_mw;
    t_ctx               n_ctx;
    logic [32:0]        n_ah;
    logic [32:0]        n_ad;
    logic [63:0]        n_nh;
    logic [63:0]        n_nd;
    logic signed [35:0] n_p;
    logic [11:0]        n_neg;
    logic [102:0]       n_wide;
    logic               n_big;
    logic [40:0]        n_mag;
    logic [31:0]        n_f;
    logic signed [32:0] n_diff;
    logic signed [50:0] n_bsh;
    logic signed [51:0] n_sum;

    assign busy     = !i_rst_n;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_mode   <= CUT_MODE_RST;
            r_scalar_cut <= SCALAR_CUT_RST;
            r_curve_exp  <= CURVE_EXP_RST;
            r_mask_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CUT_MODE:   r_cut_mode   <= i_cfg_data[1:0];
                CFG_SCALAR_CUT: r_scalar_cut <= i_cfg_data;
                CFG_CURVE_EXP:  r_curve_exp  <= i_cfg_data[15:0];
                CFG_MASK_EN:    r_mask_en    <= i_cfg_data[0];
                default:        r_mask_en    <= r_mask_en;
            endcase
        end
    end

    // Entry stage: cut selection, divisor and mask weight clamp.
    always_comb begin
        n_cut = (r_cut_mode == MODE_PIXEL) ? i_pixel_cut : r_scalar_cut;
        if (r_cut_mode == MODE_NOISY) begin
            n_d = {n_cut[31], n_cut} + {i_noise[31], i_noise};
        end else begin
            n_d = {n_cut[31], n_cut};
        end
        n_mw = (i_mask_weight > MASK_FULL) ? MASK_FULL : i_mask_weight;
    end

    always_ff @(posedge i_clk) begin
        r_a_h     <= i_height;
        r_a_cut   <= n_cut;
        r_a_d     <= n_d;
        r_a_mw    <= n_mw;
        r_a_gamma <= r_curve_exp;
        r_a_men   <= r_mask_en;
    end

    // Classification and magnitudes.
    always_comb begin
        n_ctx.h       = r_a_h;
        n_ctx.ac      = r_a_cut[31] ? 32'(-r_a_cut) : r_a_cut;
        n_ctx.cut_neg = r_a_cut[31];
        n_ctx.gamma   = r_a_gamma;
        n_ctx.men     = r_a_men;
        n_ctx.mw      = r_a_mw;
        if (r_a_h > r_a_cut) begin
            n_ctx.kind = KIND_PASS;
        end else if (r_a_d == 33'sd0 || r_a_h == 32'sd0 || (r_a_h[31] != r_a_d[32])) begin
            n_ctx.kind = KIND_DOM;
        end else begin
            n_ctx.kind = KIND_CURVE;
        end
        if (n_ctx.kind == KIND_CURVE) begin
            n_ah = r_a_h[31] ? 33'(-{r_a_h[31], r_a_h}) : {1'b0, r_a_h};
            n_ad = r_a_d[32] ? 33'(-r_a_d) : r_a_d;
        end else begin
            n_ah = 33'd1;
            n_ad = 33'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx[0] <= n_ctx;
        r_ah     <= n_ah;
        r_ad     <= n_ad;
        r_eh     <= msb_idx(r_ah);
        r_ed     <= msb_idx(r_ad);
        r_ah_c   <= r_ah;
        r_ad_c   <= r_ad;
        for (int i = 1; i < NST; i++) begin
            r_ctx[i] <= r_ctx[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            o_strobe <= 1'b0;
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_a_vld  <= n_accept;
            r_vld[0] <= r_a_vld;
            for (int i = 1; i < NST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            o_strobe <= r_vld[NST-1];
        end
    end

    // Normalize mantissas into [2^31, 2^32).
    always_comb begin
        n_nh = {r_ah_c, 31'b0} >> r_eh;
        n_nd = {r_ad_c, 31'b0} >> r_ed;
    end

    always_ff @(posedge i_clk) begin
        r_lm_h[0] <= n_nh[31:0];
        r_lm_d[0] <= n_nd[31:0];
        r_lf_h[0] <= '0;
        r_lf_d[0] <= '0;
        r_le_h[0] <= r_eh;
        r_le_d[0] <= r_ed;
    end

    // One fraction bit of log2 per stage by repeated squaring.
    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
        logic [63:0] n_sqh;
        logic [63:0] n_sqd;
        logic [32:0] n_qh;
        logic [32:0] n_qd;

        always_comb begin
            n_sqh = r_lm_h[j] * r_lm_h[j];
            n_sqd = r_lm_d[j] * r_lm_d[j];
            n_qh  = n_sqh[63:31];
            n_qd  = n_sqd[63:31];
        end

        always_ff @(posedge i_clk) begin
            r_lm_h[j+1] <= n_qh[32] ? n_qh[32:1] : n_qh[31:0];
            r_lm_d[j+1] <= n_qd[32] ? n_qd[32:1] : n_qd[31:0];
            r_lf_h[j+1] <= {r_lf_h[j][22:0], n_qh[32]};
            r_lf_d[j+1] <= {r_lf_d[j][22:0], n_qd[32]};
            r_le_h[j+1] <= r_le_h[j];
            r_le_d[j+1] <= r_le_d[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_l  <= $signed({1'b0, r_le_h[LOG_FRAC], r_lf_h[LOG_FRAC]})
              - $signed({1'b0, r_le_d[LOG_FRAC], r_lf_d[LOG_FRAC]});
        r_pg <= 48'($signed({1'b0, r_ctx[ST_L].gamma}) * r_l);
    end

    assign n_p = 36'(r_pg >>> GAMMA_FRAC);

    always_ff @(posedge i_clk) begin
        r_acc[0] <= EXP_ONE;
        r_fp[0]  <= n_p[23:0];
        r_s[0]   <= n_p[35:24] - 12'sd30;
    end

    // exp2 of the fraction: one constant factor per stage.
    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_exp
        localparam logic [30:0] T_K = exp_tab(k + 1);
        logic [61:0] n_pr;

        assign n_pr = r_acc[k] * T_K;

        always_ff @(posedge i_clk) begin
            r_acc[k+1] <= r_fp[k][LOG_FRAC-1-k] ? n_pr[60:30] : r_acc[k];
            r_fp[k+1]  <= r_fp[k];
            r_s[k+1]   <= r_s[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_ctx[ST_PROD-1].ac * r_acc[LOG_FRAC];
        r_s_p  <= r_s[LOG_FRAC];
    end

    // Scale by the integer part of the exponent and clamp the magnitude.
    always_comb begin
        n_neg  = 12'(-r_s_p);
        n_wide = '0;
        n_big  = 1'b0;
        if (r_s_p <= -12'sd63) begin
            n_wide = '0;
        end else if (r_s_p < 12'sd0) begin
            n_wide = {40'b0, r_prod >> n_neg[5:0]};
        end else if (r_s_p > 12'sd40) begin
            n_big = 1'b1;
        end else begin
            n_wide = {40'b0, r_prod} << r_s_p[5:0];
            if (n_wide > (103'd1 << 62)) begin
                n_big = 1'b1;
            end
        end
        n_mag = (n_big || n_wide > {62'b0, MAG_MAX}) ? MAG_MAX : n_wide[40:0];
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
    end

    always_comb begin
        case (r_ctx[ST_F-1].kind)
            KIND_PASS: n_f = r_ctx[ST_F-1].h;
            KIND_DOM:  n_f = '0;
            KIND_CURVE: begin
                if (r_ctx[ST_F-1].cut_neg) begin
                    n_f = sat32(-$signed({11'b0, r_mag}));
                end else begin
                    n_f = sat32($signed({11'b0, r_mag}));
                end
            end
            default:   n_f = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fsat   <= n_f;
        r_flag_f <= (r_ctx[ST_F-1].kind == KIND_DOM);
    end

    assign n_diff = $signed({r_fsat[31], r_fsat}) - $signed({r_ctx[ST_F].h[31], r_ctx[ST_F].h});

    always_ff @(posedge i_clk) begin
        r_bp     <= 51'($signed({1'b0, r_ctx[ST_F].mw}) * n_diff);
        r_flag_b <= r_flag_f;
        r_fsat_b <= r_fsat;
    end

    always_comb begin
        n_bsh = r_bp >>> 16;
        n_sum = $signed({{20{r_ctx[ST_BP].h[31]}}, r_ctx[ST_BP].h})
              + $signed({n_bsh[50], n_bsh});
    end

    always_ff @(posedge i_clk) begin
        o_new_height  <= r_ctx[ST_BP].men ? sat32(n_sum) : r_fsat_b;
        o_domain_flag <= r_flag_b;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe == $past(n_accept, LAT))
        else $error("result strobe does not match accepted word");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_domain_flag && !r_mask_en) |-> (o_new_height == 32'd0))
        else $error("flagged word without blending is not zero");

    a_log_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_L-1] |-> (r_lm_h[LOG_FRAC][31] && r_lm_d[LOG_FRAC][31]))
        else $error("log2 mantissa left its normalized range");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_PROD-1] |-> r_acc[LOG_FRAC][30])
        else $error("exp2 accumulator dropped below one");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canyon height recast testbench
// Drives directed height words, then words with random content and random sender
// gaps, predicts each reshaped height and domain flag in fixed point, and checks
// every strobed result in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb;
    import chr_pkg::*;

    class recast_board;
        logic [1:0]  mode;
        longint      scut;
        longint      gam;
        bit          men;
        bit [32:0]   want_q[$];
        int          errors;

        function new();
            mode   = CUT_MODE_RST;
            scut   = longint'($signed(SCALAR_CUT_RST));
            gam    = CURVE_EXP_RST;
            men    = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_CUT_MODE:   mode = v[1:0];
                CFG_SCALAR_CUT: scut = longint'($signed(v));
                CFG_CURVE_EXP:  gam  = v[15:0];
                default:        men  = v[0];
            endcase
        endfunction

        function longint log2_fx(bit [63:0] x);
            int        e;
            bit [63:0] m;
            longint    fr;
            e  = 0;
            fr = 0;
            for (int i = 0; i < 64; i++) if (x[i]) e = i;
            m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
            for (int i = 0; i < LOG_FRAC; i++) begin
                m  = (m * m) >> 31;
                fr = fr << 1;
                if (m >= 64'h1_0000_0000) begin
                    fr = fr | 1;
                    m  = m >> 1;
                end
            end
            return (longint'(e) << LOG_FRAC) + fr;
        endfunction

        function bit [63:0] floor_root(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b   = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function bit [63:0] pow2_frac(bit [63:0] fp);
            bit [63:0] acc;
            bit [63:0] t;
            acc = 64'd1 << EXP_FRAC;
            t   = 64'd2 << EXP_FRAC;
            for (int k = 1; k <= LOG_FRAC; k++) begin
                t = floor_root(t << EXP_FRAC);
                if (fp[LOG_FRAC - k]) acc = (acc * t) >> EXP_FRAC;
            end
            return acc;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note(logic [31:0] hi, logic [31:0] pci, logic [31:0] nzi,
                           logic [16:0] mwi);
            longint    h;
            longint    cut;
            longint    d;
            longint    f;
            longint    lv;
            longint    p;
            longint    ip;
            longint    s;
            bit [63:0] prod;
            bit [63:0] mag;
            bit [63:0] mw;
            bit        flag;
            h    = longint'($signed(hi));
            cut  = (mode == MODE_PIXEL) ? longint'($signed(pci)) : scut;
            d    = (mode == MODE_NOISY) ? cut + longint'($signed(nzi)) : cut;
            mw   = mwi;
            flag = 0;
            if (h > cut) begin
                f = h;
            end else if (d == 0 || h == 0 || ((h < 0) != (d < 0))) begin
                f    = 0;
                flag = 1;
            end else begin
                lv   = log2_fx(h < 0 ? -h : h) - log2_fx(d < 0 ? -d : d);
                p    = (gam * lv) >>> GAMMA_FRAC;
                ip   = p >>> LOG_FRAC;
                prod = $unsigned(cut < 0 ? -cut : cut) * pow2_frac(p - (ip << LOG_FRAC));
                s    = ip - EXP_FRAC;
                if (s <= -63) mag = 0;
                else if (s < 0) mag = prod >> (-s);
                else if (s == 0) mag = prod;
                else if (s > 40 || prod > (64'd1 << (62 - s))) mag = 64'd1 << 40;
                else mag = prod << s;
                if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
                f = (cut < 0) ? -longint'(mag) : longint'(mag);
            end
            f = clip32(f);
            if (men) begin
                if (mw > 65536) mw = 65536;
                f = clip32(h + ((longint'(mw) * (f - h)) >>> 16));
            end
            want_q.push_back({flag, f[31:0]});
        endfunction

        function void check(logic [31:0] nh, logic fl);
            bit [32:0] w;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected word nh=%h flag=%b", $time, nh, fl);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (w[31:0] !== nh) begin
                $display("%0t: new_height expected %h actual %h", $time, w[31:0], nh);
                errors++;
            end
            if (w[32] !== fl) begin
                $display("%0t: domain_flag expected %b actual %b", $time, w[32], fl);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic [31:0]          i_height = '0;
    logic [31:0]          i_pixel_cut = '0;
    logic [31:0]          i_noise = '0;
    logic [16:0]          i_mask_weight = '0;
    logic                 o_strobe;
    logic [31:0]          o_new_height;
    logic                 o_domain_flag;

    recast_board board = new();
    int          gap_pct;
    int          quiet_cycles = 0;

    canyon_height_recast u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note(i_height, i_pixel_cut, i_noise, i_mask_weight);
            end
            if (o_strobe) begin
                board.check(o_new_height, o_domain_flag);
            end
            if ((start && !busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles > 2000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        start       <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= $urandom;
    endtask

    task automatic set_all(logic [1:0] m, logic [31:0] c, logic [15:0] g, logic e);
        write_reg(CFG_CUT_MODE, {30'd0, m});
        write_reg(CFG_SCALAR_CUT, c);
        write_reg(CFG_CURVE_EXP, {16'd0, g});
        write_reg(CFG_MASK_EN, {31'd0, e});
    endtask

    task automatic send_word(logic [31:0] h, logic [31:0] pc, logic [31:0] nz,
                             logic [16:0] mw);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_height      <= h;
        i_pixel_cut   <= pc;
        i_noise       <= nz;
        i_mask_weight <= mw;
        while (busy) @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.want_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        logic [31:0] v;
        if ($urandom_range(3) == 0) return $urandom;
        v = $urandom >> $urandom_range(31);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic random_word();
        logic [31:0] h;
        logic [31:0] c;
        logic [16:0] mw;
        c = (board.mode == MODE_PIXEL) ? rand_val() : board.scut[31:0];
        case ($urandom_range(3))
            0:       h = rand_val();
            1:       h = c - ($urandom >> $urandom_range(31));
            2:       h = c - $urandom_range(3);
            default: h = (c >>> $urandom_range(8)) - $urandom_range(255);
        endcase
        if (board.mode != MODE_PIXEL && $urandom_range(1)) c = rand_val();
        mw = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        send_word(h, c, ($urandom_range(2) == 0) ? rand_val() : $urandom_range(3) - 1, mw);
    endtask

    initial begin
        gap_pct      = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(32'h0002_0000, 32'h0001_0000, 0, 0);
        send_word(32'h0001_0000, 32'h0001_0000, 0, 0);
        send_word(32'h0000_8000, 32'h0001_0000, 0, 0);
        send_word(32'h0000_0001, 32'h7FFF_FFFF, 0, 0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_word(32'h8000_0000, 32'h8000_0000, 0, 0);
        send_word(32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
        send_word(0, 32'h0001_0000, 0, 0);
        send_word(32'hFFFF_0000, 0, 0, 0);
        send_word(32'hFFFF_0000, 32'h0001_0000, 0, 0);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        drain();
        set_all(MODE_NOISY, 32'h0001_0000, 16'hFFFF, 1'b1);
        send_word(32'h0000_8000, 0, 32'h8000_0000, 17'd65536);
        send_word(32'h0000_8000, 0, 32'hFFFF_0000, 17'd0);
        send_word(32'h0000_8000, 0, 32'h7FFF_FFFF, 17'h1FFFF);
        send_word(32'h0000_0001, 0, 0, 17'd32768);
        send_word(32'h8000_0000, 0, 32'h8000_0000, 17'd65537);
        drain();
        set_all(2'd3, 32'h8000_0000, 16'd0, 1'b0);
        send_word(32'h8000_0000, 0, 0, 17'h1FFFF);
        send_word(32'hC000_0000, 0, 0, 0);
        drain();
        set_all(MODE_PIXEL, 32'h7FFF_FFFF, 16'd1, 1'b1);
        send_word(32'h0000_0001, 32'h7FFF_FFFF, 0, 17'd65536);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 17'd40000);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 26 : (ph == 1) ? 78 : 0;
            for (int ch = 0; ch < 5; ch++) begin
                if (ch == 0) begin
                    set_all(2'($urandom_range(3)), (ph == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                            (ph == 2) ? 16'hFFFF : 16'd1, ph[0]);
                end else begin
                    set_all(2'($urandom_range(3)), rand_val(),
                            $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2048, 8192)),
                            1'($urandom));
                end
                repeat (108) random_word();
                drain();
            end
        end

        repeat (70) @(posedge i_clk);
        if (board.errors == 0 && board.want_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
